@@ hw/rtl/udp_port_packet_filter_assert.svh @@
// Assertion macros for the UDP port filter checker.
// Both expect signals named clk and rst_n in the scope of use.
`ifndef UDP_PORT_PACKET_FILTER_ASSERT_SVH
`define UDP_PORT_PACKET_FILTER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define UDPF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define UDPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/udpf_pkg.sv @@
`default_nettype none

package udpf_pkg;

    // Frame size limit
    localparam int unsigned MAX_FRAME_BYTES_DEF = 65535;

    // Byte positions inside the frame
    localparam logic [15:0] ETH_TYPE_POS    = 16'd12;
    localparam logic [15:0] INNER_TYPE_POS  = 16'd16;
    localparam logic [15:0] UNTAGGED_IP_POS = 16'd14;
    localparam logic [15:0] TAGGED_IP_POS   = 16'd18;
    localparam logic [15:0] IP_PROTO_OFS    = 16'd9;
    localparam logic [15:0] IP_HDR_BYTES    = 16'd20;
    localparam logic [15:0] UDP_HDR_BYTES   = 16'd8;

    // Header codes
    localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
    localparam logic [15:0] ETYPE_VLAN   = 16'h8100;
    localparam logic [15:0] ETYPE_QINQ   = 16'h88A8;
    localparam logic [3:0]  IP_VERSION_4 = 4'd4;
    localparam logic [7:0]  IP_PROTO_UDP = 8'd17;

    // Register map (word index)
    localparam logic REG_FILTER_PORT = 1'b0;

endpackage

`default_nettype wire

@@ hw/rtl/udp_port_packet_filter.sv @@
// Channel   Signals                                   Transfer
// item      item_valid/item_ready, data_byte,         one frame byte
//           last_byte
// result    result_valid/result_ready, frame_match,   one verdict per frame
//           frame_bytes
// config    psel/penable/pwrite/paddr/pwdata/prdata   filter_port at 0x0
//
// One byte per clock while no result stalls the input; the last byte of a frame
// passes the input register, then is parsed and judged into the result register.
// Reset clears the filter port, the per-frame parse state and both valid flags.
// A waiting result stalls the input only while the held byte ends a frame.
`default_nettype none

module udp_port_packet_filter #(
    parameter int unsigned MAX_FRAME_BYTES = udpf_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic             frame_match,
    output logic [15:0]      frame_bytes,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [15:0] MaxBytes = 16'(MAX_FRAME_BYTES);

    // Configuration register
    logic [15:0] filter_port_reg;

    // Input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // Per-frame parse state
    logic [15:0] byte_offset_reg, byte_offset_next;
    logic [15:0] frame_type_reg, frame_type_next;
    logic        tag_present_reg, tag_present_next;
    logic [3:0]  ip_version_reg, ip_version_next;
    logic [3:0]  header_words_reg, header_words_next;
    logic [7:0]  ip_protocol_reg, ip_protocol_next;
    logic [15:0] source_port_reg, source_port_next;
    logic [15:0] dest_port_reg, dest_port_next;

    // Result register
    logic        result_valid_reg;
    logic        frame_match_reg, frame_match_next;
    logic [15:0] frame_bytes_reg;

    logic        advance;
    logic [15:0] pos;
    logic [15:0] ip_pos;
    logic [15:0] udp_pos;
    logic [15:0] judge_ip_pos;
    logic [15:0] judge_udp_pos;

    // APB: always ready, register at word 0
    assign pready = 1'b1;
    assign prdata = (paddr[2] == udpf_pkg::REG_FILTER_PORT) ?
                    {16'd0, filter_port_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_port_reg <= 16'd0;
        end
        else if (psel && penable && pwrite && pready &&
                 (paddr[2] == udpf_pkg::REG_FILTER_PORT))
        begin
            filter_port_reg <= pwdata[15:0];
        end
    end

    // Consume the held byte unless it ends a frame while a result still waits
    assign advance    = in_valid_reg &&
                        (!in_last_reg || !result_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
    end

    // Parse one byte into the next header state
    always_comb
    begin
        pos               = byte_offset_reg;
        frame_type_next   = frame_type_reg;
        tag_present_next  = tag_present_reg;
        ip_version_next   = ip_version_reg;
        header_words_next = header_words_reg;
        ip_protocol_next  = ip_protocol_reg;
        source_port_next  = source_port_reg;
        dest_port_next    = dest_port_reg;
        byte_offset_next  = byte_offset_reg;
        ip_pos  = tag_present_reg ? udpf_pkg::TAGGED_IP_POS : udpf_pkg::UNTAGGED_IP_POS;
        udp_pos = ip_pos;

        if (pos < MaxBytes)
        begin
            byte_offset_next = pos + 16'd1;

            // Outer EtherType, then check for one VLAN tag
            if (pos == udpf_pkg::ETH_TYPE_POS || pos == udpf_pkg::ETH_TYPE_POS + 16'd1)
            begin
                frame_type_next = {frame_type_next[7:0], in_byte_reg};
            end
            if (pos == udpf_pkg::ETH_TYPE_POS + 16'd1 &&
                (frame_type_next == udpf_pkg::ETYPE_VLAN ||
                 frame_type_next == udpf_pkg::ETYPE_QINQ))
            begin
                tag_present_next = 1'b1;
            end
            // Inner EtherType behind the tag
            if (tag_present_next && (pos == udpf_pkg::INNER_TYPE_POS ||
                                     pos == udpf_pkg::INNER_TYPE_POS + 16'd1))
            begin
                frame_type_next = {frame_type_next[7:0], in_byte_reg};
            end

            // IPv4 header fields
            if (pos == ip_pos)
            begin
                ip_version_next   = in_byte_reg[7:4];
                header_words_next = in_byte_reg[3:0];
            end
            if (pos == ip_pos + udpf_pkg::IP_PROTO_OFS)
            begin
                ip_protocol_next = in_byte_reg;
            end

            // UDP ports, located by the header length nibble
            udp_pos = ip_pos + {10'd0, header_words_next, 2'b00};
            if (pos >= ip_pos)
            begin
                if (pos == udp_pos || pos == udp_pos + 16'd1)
                begin
                    source_port_next = {source_port_next[7:0], in_byte_reg};
                end
                if (pos == udp_pos + 16'd2 || pos == udp_pos + 16'd3)
                begin
                    dest_port_next = {dest_port_next[7:0], in_byte_reg};
                end
            end
        end
    end

    // Judge the frame from the state after its last byte
    always_comb
    begin
        judge_ip_pos  = tag_present_next ? udpf_pkg::TAGGED_IP_POS :
                                           udpf_pkg::UNTAGGED_IP_POS;
        judge_udp_pos = judge_ip_pos + {10'd0, header_words_next, 2'b00};
        if (filter_port_reg == 16'd0)
        begin
            frame_match_next = 1'b1;
        end
        else if (frame_type_next != udpf_pkg::ETYPE_IPV4 ||
                 byte_offset_next < judge_ip_pos + udpf_pkg::IP_HDR_BYTES ||
                 ip_version_next != udpf_pkg::IP_VERSION_4 ||
                 ip_protocol_next != udpf_pkg::IP_PROTO_UDP ||
                 byte_offset_next < judge_udp_pos + udpf_pkg::UDP_HDR_BYTES)
        begin
            frame_match_next = 1'b0;
        end
        else
        begin
            frame_match_next = (source_port_next == filter_port_reg) ||
                               (dest_port_next == filter_port_reg);
        end
    end

    // Hold parse state; clear it after the last byte of a frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg  <= 16'd0;
            frame_type_reg   <= 16'd0;
            tag_present_reg  <= 1'b0;
            ip_version_reg   <= 4'd0;
            header_words_reg <= 4'd0;
            ip_protocol_reg  <= 8'd0;
            source_port_reg  <= 16'd0;
            dest_port_reg    <= 16'd0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                byte_offset_reg  <= 16'd0;
                frame_type_reg   <= 16'd0;
                tag_present_reg  <= 1'b0;
                ip_version_reg   <= 4'd0;
                header_words_reg <= 4'd0;
                ip_protocol_reg  <= 8'd0;
                source_port_reg  <= 16'd0;
                dest_port_reg    <= 16'd0;
            end
            else
            begin
                byte_offset_reg  <= byte_offset_next;
                frame_type_reg   <= frame_type_next;
                tag_present_reg  <= tag_present_next;
                ip_version_reg   <= ip_version_next;
                header_words_reg <= header_words_next;
                ip_protocol_reg  <= ip_protocol_next;
                source_port_reg  <= source_port_next;
                dest_port_reg    <= dest_port_next;
            end
        end
    end

    // Result register: load on the last byte, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            frame_match_reg <= frame_match_next;
            frame_bytes_reg <= byte_offset_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign frame_match  = frame_match_reg;
    assign frame_bytes  = frame_bytes_reg;

endmodule

`default_nettype wire

@@ hw/rtl/udpf_checker.sv @@
`default_nettype none

`include "udp_port_packet_filter_assert.svh"

module udpf_checker #(
    parameter int unsigned MAX_FRAME_BYTES = udpf_pkg::MAX_FRAME_BYTES_DEF
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        item_ready,
    input wire logic        result_valid,
    input wire logic        result_ready,
    input wire logic        frame_match,
    input wire logic [15:0] frame_bytes
);

    localparam logic [15:0] MaxBytes = 16'(MAX_FRAME_BYTES);

    // Stalled result holds its payload
    `UDPF_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
        result_valid && $stable(frame_match) && $stable(frame_bytes),
        "stalled result changed")

    // Input stalls only behind a waiting result
    `UDPF_ASSERT_SAME(a_stall_cause, !item_ready, result_valid && !result_ready,
        "input stalled without a waiting result")

    // Every frame holds at least its last byte
    `UDPF_ASSERT_SAME(a_bytes_nonzero, result_valid, frame_bytes != 16'd0,
        "zero frame length reported")

    // Length saturates at the limit
    `UDPF_ASSERT_SAME(a_bytes_limit, result_valid, frame_bytes <= MaxBytes,
        "frame length above limit")

endmodule

bind udp_port_packet_filter udpf_checker #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
) u_udpf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .frame_match  (frame_match),
    .frame_bytes  (frame_bytes)
);

`default_nettype wire

@@ test/tb_udp_port_packet_filter.sv @@
`default_nettype none

module tb_udp_port_packet_filter;

    localparam int unsigned FRAME_CAP = udpf_pkg::MAX_FRAME_BYTES_DEF;
    localparam int unsigned WORD_BYTES = 4;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int ITEM_TARGET = 850;
    localparam int MIN_PHASES = 4;
    localparam logic [2:0] FILTER_PORT_ADDR = {udpf_pkg::REG_FILTER_PORT, 2'b00};

    typedef struct packed {
        logic        match;
        logic [15:0] bytes;
    } verdict_t;

    typedef enum int {TAG_NONE, TAG_8021Q, TAG_8021AD} tag_kind_t;

    // Tracks the parse state of the frame in flight and the verdicts still owed
    class udp_verdict_board;
        logic [15:0] port_sel;
        logic [15:0] offset;
        logic [15:0] etype;
        bit          vlan;
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        verdict_t    verdicts_due[$];
        int          failures;
        int          frames_seen;
        int          matches_seen;

        function new();
            port_sel = 16'h0000;
            failures = 0;
            frames_seen = 0;
            matches_seen = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            offset = 16'h0000;
            etype = 16'h0000;
            vlan = 1'b0;
            ver = 4'h0;
            ihl = 4'h0;
            proto = 8'h00;
            sport = 16'h0000;
            dport = 16'h0000;
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("mismatch %0d: %s", failures, msg);
        endfunction

        // Advance the parse by one transferred byte; owe a verdict on the last one
        function void note_byte(logic [7:0] b, logic fin);
            int unsigned p;
            int unsigned ip_at;
            int unsigned udp_at;
            int unsigned len;
            verdict_t v;
            p = 32'(offset);
            ip_at = vlan ? 32'(udpf_pkg::TAGGED_IP_POS) : 32'(udpf_pkg::UNTAGGED_IP_POS);
            // bytes past the cap are dropped from both count and parse
            if (p < FRAME_CAP)
            begin
                if (p == udpf_pkg::ETH_TYPE_POS || p == udpf_pkg::ETH_TYPE_POS + 1)
                    etype = {etype[7:0], b};
                if (p == udpf_pkg::ETH_TYPE_POS + 1 &&
                    (etype == udpf_pkg::ETYPE_VLAN || etype == udpf_pkg::ETYPE_QINQ))
                    vlan = 1'b1;
                if (vlan && (p == udpf_pkg::INNER_TYPE_POS ||
                             p == udpf_pkg::INNER_TYPE_POS + 1))
                    etype = {etype[7:0], b};
                if (p == ip_at)
                begin
                    ver = b[7:4];
                    ihl = b[3:0];
                end
                if (p == ip_at + udpf_pkg::IP_PROTO_OFS)
                    proto = b;
                if (p >= ip_at)
                begin
                    // header nibble is trusted as is, even below five
                    udp_at = ip_at + ihl * WORD_BYTES;
                    if (p == udp_at || p == udp_at + 1)
                        sport = {sport[7:0], b};
                    if (p == udp_at + 2 || p == udp_at + 3)
                        dport = {dport[7:0], b};
                end
                offset = 16'(p + 1);
            end
            if (!fin)
                return;

            // judge the frame as cut to the counted bytes
            len = 32'(offset);
            ip_at = vlan ? 32'(udpf_pkg::TAGGED_IP_POS) : 32'(udpf_pkg::UNTAGGED_IP_POS);
            udp_at = ip_at + ihl * WORD_BYTES;
            v.bytes = offset;
            if (port_sel == 16'h0000)
                v.match = 1'b1;
            else if (etype != udpf_pkg::ETYPE_IPV4 || len < ip_at + udpf_pkg::IP_HDR_BYTES)
                v.match = 1'b0;
            else if (ver != udpf_pkg::IP_VERSION_4 || proto != udpf_pkg::IP_PROTO_UDP)
                v.match = 1'b0;
            else if (len < udp_at + udpf_pkg::UDP_HDR_BYTES)
                v.match = 1'b0;
            else
                v.match = (sport == port_sel) || (dport == port_sel);
            verdicts_due.push_back(v);
            frames_seen++;
            if (v.match)
                matches_seen++;
            clear_frame();
        endfunction

        // Compare one transferred verdict with the oldest one owed
        function void check_verdict(logic m, logic [15:0] n);
            verdict_t v;
            if (verdicts_due.size() == 0)
            begin
                note_failure($sformatf("verdict with none owed: match %0b, bytes %0d", m, n));
                return;
            end
            v = verdicts_due.pop_front();
            if (m !== v.match)
                note_failure($sformatf("frame_match expected %0b, got %0b (frame of %0d bytes)",
                                       v.match, m, v.bytes));
            if (n !== v.bytes)
                note_failure($sformatf("frame_bytes expected %0d, got %0d", v.bytes, n));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic        frame_match;
    logic [15:0] frame_bytes;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'b000;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    udp_verdict_board sb = new();
    logic [7:0] frame_buf[$];
    int burst_left = 0;
    bit steady = 1'b0;
    int bytes_sent = 0;
    int ports_written = 0;
    int rx_tick = 0;
    int rx_mode = 0;

    udp_port_packet_filter #(
        .MAX_FRAME_BYTES(FRAME_CAP)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .data_byte(data_byte),
        .last_byte(last_byte),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .frame_match(frame_match),
        .frame_bytes(frame_bytes),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #6 clk = ~clk;

    // Check each verdict transfer and stall the result side in changing modes
    always @(posedge clk)
    begin
        if (result_valid && result_ready)
            sb.check_verdict(frame_match, frame_bytes);
        rx_tick = rx_tick + 1;
        if (rx_tick % 40 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: result_ready <= 1'b1;
            1: result_ready <= 1'($urandom_range(0, 1));
            2: result_ready <= ($urandom_range(0, 3) == 0);
            default: result_ready <= ((rx_tick % 5) < 2);
        endcase
    end

    // Transfer one frame byte, opening a new burst after a random gap
    task automatic push_byte(logic [7:0] b, logic fin);
        int gap;
        if (!steady && burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        item_valid <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        do @(posedge clk); while (!item_ready);
        sb.note_byte(b, fin);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_buf[i])
            push_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    task automatic trim_frame(int unsigned n);
        while (frame_buf.size() > n)
            void'(frame_buf.pop_back());
    endtask

    // Hold the input idle until every owed verdict has been transferred
    task automatic settle();
        item_valid <= 1'b0;
        while (sb.verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB read of the port register, compared with the expected value
    task automatic check_port(logic [15:0] want);
        logic [31:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= FILTER_PORT_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (got[15:0] !== want)
            sb.note_failure($sformatf("filter_port read expected %h, got %h", want, got[15:0]));
    endtask

    task automatic write_port(logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= FILTER_PORT_ADDR;
        pwdata <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.port_sel = value;
        ports_written++;
        check_port(value);
    endtask

    task automatic push_word(logic [15:0] w);
        frame_buf.push_back(w[15:8]);
        frame_buf.push_back(w[7:0]);
    endtask

    // Build an Ethernet/IPv4/UDP frame; UDP header sits ihl words into the IP header
    task automatic make_frame(tag_kind_t tag, logic [15:0] etype, logic [3:0] ver,
                              logic [3:0] ihl, logic [7:0] proto,
                              logic [15:0] sp, logic [15:0] dp, int extra);
        int unsigned u;
        int unsigned span;
        logic [7:0] ip_area[$];
        frame_buf.delete();
        repeat (12) frame_buf.push_back(8'($urandom));
        if (tag != TAG_NONE)
        begin
            push_word((tag == TAG_8021Q) ? udpf_pkg::ETYPE_VLAN : udpf_pkg::ETYPE_QINQ);
            push_word(16'($urandom));
        end
        push_word(etype);
        u = ihl * WORD_BYTES;
        span = (u + udpf_pkg::UDP_HDR_BYTES > udpf_pkg::IP_HDR_BYTES) ?
               u + udpf_pkg::UDP_HDR_BYTES : 32'(udpf_pkg::IP_HDR_BYTES);
        span += extra;
        repeat (span) ip_area.push_back(8'($urandom));
        ip_area[u] = sp[15:8];
        ip_area[u + 1] = sp[7:0];
        ip_area[u + 2] = dp[15:8];
        ip_area[u + 3] = dp[7:0];
        // version and protocol win where a small nibble overlaps them
        ip_area[0] = {ver, ihl};
        ip_area[udpf_pkg::IP_PROTO_OFS] = proto;
        foreach (ip_area[i])
            frame_buf.push_back(ip_area[i]);
    endtask

    function automatic logic [15:0] pick_port(logic [15:0] port);
        case ($urandom_range(0, 5))
            0, 1: return port;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly well-formed frames with random content, some truncated, some noise
    task automatic random_frame(logic [15:0] port);
        tag_kind_t tag;
        logic [15:0] etype;
        logic [3:0] ver;
        logic [3:0] ihl;
        logic [7:0] proto;
        if ($urandom_range(0, 9) < 7)
        begin
            tag = tag_kind_t'($urandom_range(0, 2));
            etype = ($urandom_range(0, 9) == 0) ? 16'($urandom) : udpf_pkg::ETYPE_IPV4;
            ver = ($urandom_range(0, 9) == 0) ? 4'($urandom) : udpf_pkg::IP_VERSION_4;
            ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
            proto = ($urandom_range(0, 9) == 0) ? 8'($urandom) : udpf_pkg::IP_PROTO_UDP;
            make_frame(tag, etype, ver, ihl, proto, pick_port(port), pick_port(port),
                       $urandom_range(0, 18));
            if ($urandom_range(0, 7) == 0)
                trim_frame($urandom_range(1, frame_buf.size()));
        end
        else
        begin
            frame_buf.delete();
            repeat ($urandom_range(1, 40)) frame_buf.push_back(8'($urandom));
        end
        steady = ($urandom_range(0, 4) == 0);
        send_frame();
    endtask

    initial
    begin
        logic [15:0] port;
        int phase;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset port of zero passes even a one-byte frame
        check_port(16'h0000);
        frame_buf = {8'h00};
        send_frame();
        settle();

        write_port(16'h1234);
        // source match, destination match, neither
        make_frame(TAG_NONE, udpf_pkg::ETYPE_IPV4, udpf_pkg::IP_VERSION_4, 4'd5,
                   udpf_pkg::IP_PROTO_UDP, 16'h1234, 16'h0050, 0);
        send_frame();
        make_frame(TAG_NONE, udpf_pkg::ETYPE_IPV4, udpf_pkg::IP_VERSION_4, 4'd5,
                   udpf_pkg::IP_PROTO_UDP, 16'h0050, 16'h1234, 6);
        send_frame();
        make_frame(TAG_NONE, udpf_pkg::ETYPE_IPV4, udpf_pkg::IP_VERSION_4, 4'd5,
                   udpf_pkg::IP_PROTO_UDP, 16'h1235, 16'h3412, 3);
        send_frame();
        // single VLAN tag and stacked-VLAN outer tag
        make_frame(TAG_8021Q, udpf_pkg::ETYPE_IPV4, udpf_pkg::IP_VERSION_4, 4'd5,
                   udpf_pkg::IP_PROTO_UDP, 16'h0001, 16'h1234, 2);
        send_frame();
        make_frame(TAG_8021AD, udpf_pkg::ETYPE_IPV4, udpf_pkg::IP_VERSION_4, 4'd5,
                   udpf_pkg::IP_PROTO_UDP, 16'h1234, 16'h0002, 0);
        send_frame();
        make_frame(TAG_8021Q, 16'h86DD, udpf_pkg::IP_VERSION_4, 4'd5,
                   udpf_pkg::IP_PROTO_UDP, 16'h1234, 16'h1234, 0);
        send_frame();
        // wrong EtherType, protocol, version
        make_frame(TAG_NONE, 16'h86DD, udpf_pkg::IP_VERSION_4, 4'd5,
                   udpf_pkg::IP_PROTO_UDP, 16'h1234, 16'h1234, 0);
        send_frame();
        make_frame(TAG_NONE, udpf_pkg::ETYPE_IPV4, udpf_pkg::IP_VERSION_4, 4'd5,
                   8'd6, 16'h1234, 16'h1234, 0);
        send_frame();
        make_frame(TAG_NONE, udpf_pkg::ETYPE_IPV4, 4'd6, 4'd5,
                   udpf_pkg::IP_PROTO_UDP, 16'h1234, 16'h1234, 0);
        send_frame();
        // small header nibbles put the ports inside the IP header, the largest one far behind it
        make_frame(TAG_NONE, udpf_pkg::ETYPE_IPV4, udpf_pkg::IP_VERSION_4, 4'd2,
                   udpf_pkg::IP_PROTO_UDP, 16'h0000, 16'h1234, 4);
        send_frame();
        make_frame(TAG_NONE, udpf_pkg::ETYPE_IPV4, udpf_pkg::IP_VERSION_4, 4'd0,
                   udpf_pkg::IP_PROTO_UDP, 16'h0000, 16'h1234, 0);
        send_frame();
        make_frame(TAG_8021Q, udpf_pkg::ETYPE_IPV4, udpf_pkg::IP_VERSION_4, 4'd15,
                   udpf_pkg::IP_PROTO_UDP, 16'h1234, 16'h0000, 4);
        send_frame();
        // short frames: one byte shy of the UDP header, exactly enough, inside IP header
        make_frame(TAG_NONE, udpf_pkg::ETYPE_IPV4, udpf_pkg::IP_VERSION_4, 4'd5,
                   udpf_pkg::IP_PROTO_UDP, 16'h1234, 16'h1234, 0);
        trim_frame(41);
        send_frame();
        make_frame(TAG_8021AD, udpf_pkg::ETYPE_IPV4, udpf_pkg::IP_VERSION_4, 4'd5,
                   udpf_pkg::IP_PROTO_UDP, 16'h1234, 16'h0000, 0);
        send_frame();
        make_frame(TAG_NONE, udpf_pkg::ETYPE_IPV4, udpf_pkg::IP_VERSION_4, 4'd5,
                   udpf_pkg::IP_PROTO_UDP, 16'h1234, 16'h1234, 0);
        trim_frame(20);
        send_frame();
        settle();

        // all-ones extremes
        write_port(16'hFFFF);
        make_frame(TAG_NONE, udpf_pkg::ETYPE_IPV4, udpf_pkg::IP_VERSION_4, 4'd5,
                   udpf_pkg::IP_PROTO_UDP, 16'h0000, 16'hFFFF, 0);
        send_frame();
        frame_buf = {8'hFF, 8'hFF, 8'hFF};
        send_frame();
        settle();

        // zero port passes garbage
        write_port(16'h0000);
        frame_buf = {8'h81, 8'h00, 8'hFF, 8'h00, 8'h7E};
        send_frame();
        settle();

        // random phases, each under its own filter port, until the byte budget is spent
        phase = 0;
        while (phase < MIN_PHASES || bytes_sent < ITEM_TARGET)
        begin
            case (phase % 4)
                0: port = 16'($urandom);
                1: port = 16'hFFFF;
                2: port = 16'h0000;
                default: port = 16'($urandom_range(1, 255));
            endcase
            write_port(port);
            repeat ($urandom_range(1, 3))
                random_frame(port);
            settle();
            phase++;
        end

        settle();
        repeat (6) @(posedge clk);
        $display("run covered %0d frames over %0d bytes, %0d of them matching",
                 sb.frames_seen, bytes_sent, sb.matches_seen);
        $display("filter port written %0d times across %0d random phases, %0d mismatches",
                 ports_written, phase, sb.failures);
        if (sb.failures == 0 && sb.verdicts_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial
    begin
        #(12 * 600000);
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

@@ udp_port_packet_filter.f @@
+incdir+hw/rtl
hw/rtl/udpf_pkg.sv
hw/rtl/udp_port_packet_filter.sv
hw/rtl/udpf_checker.sv
test/tb_udp_port_packet_filter.sv
